>>> rtl/core/assert_macros.svh
// assertion macros used by the checker file hmcc_checker.sv
// no dependencies; include guard below
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/hmcc_pkg.sv
// types, codes and byte helpers for the markup character classifier
// no dependencies
`default_nettype none

package hmcc_pkg;

  typedef logic [2:0] mode_t;
  typedef logic [1:0] class_t;

  localparam mode_t MODE_NORMAL  = 3'd0;
  localparam mode_t MODE_TAG     = 3'd1;
  localparam mode_t MODE_DQ      = 3'd2;
  localparam mode_t MODE_SQ      = 3'd3;
  localparam mode_t MODE_COMMENT = 3'd4;

  localparam class_t CLS_NORMAL  = 2'd0;
  localparam class_t CLS_TAG     = 2'd1;
  localparam class_t CLS_STRING  = 2'd2;
  localparam class_t CLS_COMMENT = 2'd3;

  localparam logic [7:0] CHAR_LT    = 8'h3C;
  localparam logic [7:0] CHAR_GT    = 8'h3E;
  localparam logic [7:0] CHAR_BANG  = 8'h21;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_DQ    = 8'h22;
  localparam logic [7:0] CHAR_SQ    = 8'h27;

  localparam int MaxResults = 4;

  // utf-8 continuation byte 10xxxxxx
  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  // continuation bytes following a lead byte
  function automatic logic [1:0] extra_bytes(input logic [7:0] b);
    logic [1:0] r;
    r = 2'd0;
    if (b[7:5] == 3'b110) r = 2'd1;
    else if (b[7:4] == 4'b1110) r = 2'd2;
    else if (b[7:3] == 5'b11110) r = 2'd3;
    return r;
  endfunction

  // byte of the comment opener at a given position
  function automatic logic [7:0] opener_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0: r = CHAR_LT;
      2'd1: r = CHAR_BANG;
      default: r = CHAR_DASH;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/html_markup_char_classifier_core.sv
// markup character classifier: one highlight class per utf-8 character
// depends on hmcc_pkg
// output: the results of a byte are registered, the first valid in the cycle after the byte is accepted
// throughput: one byte per cycle while each byte yields at most one result and the
//   output is ready; a byte that yields several results (up to four) holds the input
//   side until its last result is taken, since the result buffer drains one result per cycle
// reset: synchronous, clears scan state and drops any results still buffered
`default_nettype none

module html_markup_char_classifier_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] text_byte,
  input  wire logic       line_end,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      char_class,
  output logic            run_last
);

  // scan state
  hmcc_pkg::mode_t scan_mode;
  logic [1:0]      pending_prefix;
  logic [1:0]      dash_run;
  logic [1:0]      skip_left;

  hmcc_pkg::mode_t scan_mode_next;
  logic [1:0]      pending_prefix_next;
  logic [1:0]      dash_run_next;
  logic [1:0]      skip_left_next;

  // result buffer: entry 0 is the head, shifts down as results leave
  hmcc_pkg::class_t res_cls [hmcc_pkg::MaxResults];
  logic [2:0]       res_cnt;

  // results built for the byte at the input
  hmcc_pkg::class_t cls_next [hmcc_pkg::MaxResults];
  logic [2:0]       n_next;

  hmcc_pkg::mode_t  mode_eff;
  logic             do_scan;
  logic             in_fire;
  logic             out_fire;

  assign out_valid  = (res_cnt != 3'd0);
  assign char_class = res_cls[0];
  assign run_last   = (res_cnt == 3'd1);
  // a new byte may enter while the buffer is empty or once it empties this cycle
  assign in_ready   = (res_cnt == 3'd0) || ((res_cnt == 3'd1) && out_ready);
  assign in_fire    = in_valid && in_ready;
  assign out_fire   = out_valid && out_ready;

  // per-byte scan, one pass
  always_comb begin
    mode_eff = (scan_mode > hmcc_pkg::MODE_COMMENT) ? hmcc_pkg::MODE_NORMAL : scan_mode;
    scan_mode_next      = mode_eff;
    pending_prefix_next = pending_prefix;
    dash_run_next       = dash_run;
    skip_left_next      = skip_left;
    n_next              = 3'd0;
    do_scan             = 1'b0;
    for (int k = 0; k < hmcc_pkg::MaxResults; k++) begin
      cls_next[k] = hmcc_pkg::CLS_NORMAL;
    end

    if (skip_left != 2'd0) begin
      // skipped byte, only a stray non-continuation byte shows up
      skip_left_next = skip_left - 2'd1;
      if (!hmcc_pkg::is_cont(text_byte)) begin
        cls_next[0] = hmcc_pkg::CLS_NORMAL;
        n_next      = 3'd1;
      end
    end else if (mode_eff == hmcc_pkg::MODE_NORMAL) begin
      if (pending_prefix != 2'd0) begin
        if (text_byte == hmcc_pkg::opener_byte(pending_prefix)) begin
          if (pending_prefix == 2'd3) begin
            // full opener seen, all four bytes are comment
            for (int k = 0; k < hmcc_pkg::MaxResults; k++) begin
              cls_next[k] = hmcc_pkg::CLS_COMMENT;
            end
            n_next              = 3'd4;
            pending_prefix_next = 2'd0;
            scan_mode_next      = hmcc_pkg::MODE_COMMENT;
            dash_run_next       = 2'd0;
          end else begin
            pending_prefix_next = pending_prefix + 2'd1;
          end
        end else begin
          // mismatch: held bytes become tag, then scan this byte in tag mode
          for (int k = 0; k < 3; k++) begin
            if (2'(k) < pending_prefix) begin
              cls_next[k] = hmcc_pkg::CLS_TAG;
            end
          end
          n_next              = {1'b0, pending_prefix};
          pending_prefix_next = 2'd0;
          scan_mode_next      = hmcc_pkg::MODE_TAG;
          do_scan             = 1'b1;
        end
      end else if (text_byte == hmcc_pkg::CHAR_LT) begin
        pending_prefix_next = 2'd1;
      end else if (!hmcc_pkg::is_cont(text_byte)) begin
        cls_next[0] = hmcc_pkg::CLS_NORMAL;
        n_next      = 3'd1;
      end
    end else begin
      do_scan = 1'b1;
    end

    if (do_scan) begin
      case (scan_mode_next)
        hmcc_pkg::MODE_TAG: begin
          if (text_byte == hmcc_pkg::CHAR_GT) begin
            cls_next[n_next[1:0]] = hmcc_pkg::CLS_TAG;
            n_next                = n_next + 3'd1;
            scan_mode_next        = hmcc_pkg::MODE_NORMAL;
          end else if (text_byte == hmcc_pkg::CHAR_DQ) begin
            cls_next[n_next[1:0]] = hmcc_pkg::CLS_STRING;
            n_next                = n_next + 3'd1;
            scan_mode_next        = hmcc_pkg::MODE_DQ;
          end else if (text_byte == hmcc_pkg::CHAR_SQ) begin
            cls_next[n_next[1:0]] = hmcc_pkg::CLS_STRING;
            n_next                = n_next + 3'd1;
            scan_mode_next        = hmcc_pkg::MODE_SQ;
          end else begin
            if (!hmcc_pkg::is_cont(text_byte)) begin
              cls_next[n_next[1:0]] = hmcc_pkg::CLS_TAG;
              n_next                = n_next + 3'd1;
            end
            skip_left_next = hmcc_pkg::extra_bytes(text_byte);
          end
        end
        hmcc_pkg::MODE_DQ, hmcc_pkg::MODE_SQ: begin
          if ((scan_mode_next == hmcc_pkg::MODE_DQ && text_byte == hmcc_pkg::CHAR_DQ) ||
              (scan_mode_next == hmcc_pkg::MODE_SQ && text_byte == hmcc_pkg::CHAR_SQ)) begin
            cls_next[n_next[1:0]] = hmcc_pkg::CLS_STRING;
            n_next                = n_next + 3'd1;
            scan_mode_next        = hmcc_pkg::MODE_TAG;
          end else begin
            if (!hmcc_pkg::is_cont(text_byte)) begin
              cls_next[n_next[1:0]] = hmcc_pkg::CLS_STRING;
              n_next                = n_next + 3'd1;
            end
            skip_left_next = hmcc_pkg::extra_bytes(text_byte);
          end
        end
        default: begin
          // comment body, closer needs two dashes then '>'
          if (text_byte == hmcc_pkg::CHAR_DASH) begin
            cls_next[n_next[1:0]] = hmcc_pkg::CLS_COMMENT;
            n_next                = n_next + 3'd1;
            if (dash_run < 2'd2) dash_run_next = dash_run + 2'd1;
          end else if (text_byte == hmcc_pkg::CHAR_GT && dash_run >= 2'd2) begin
            cls_next[n_next[1:0]] = hmcc_pkg::CLS_COMMENT;
            n_next                = n_next + 3'd1;
            scan_mode_next        = hmcc_pkg::MODE_NORMAL;
            dash_run_next         = 2'd0;
          end else begin
            dash_run_next = 2'd0;
            if (!hmcc_pkg::is_cont(text_byte)) begin
              cls_next[n_next[1:0]] = hmcc_pkg::CLS_COMMENT;
              n_next                = n_next + 3'd1;
            end
            skip_left_next = hmcc_pkg::extra_bytes(text_byte);
          end
        end
      endcase
    end

    if (line_end) begin
      // flush held opener bytes as tag, then start the next line clean
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < pending_prefix_next) begin
          cls_next[k] = hmcc_pkg::CLS_TAG;
        end
      end
      if (pending_prefix_next != 2'd0) begin
        n_next = {1'b0, pending_prefix_next};
      end
      scan_mode_next      = hmcc_pkg::MODE_NORMAL;
      pending_prefix_next = 2'd0;
      dash_run_next       = 2'd0;
      skip_left_next      = 2'd0;
    end
  end

  // scan state register
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode      <= hmcc_pkg::MODE_NORMAL;
      pending_prefix <= 2'd0;
      dash_run       <= 2'd0;
      skip_left      <= 2'd0;
    end else if (in_fire) begin
      scan_mode      <= scan_mode_next;
      pending_prefix <= pending_prefix_next;
      dash_run       <= dash_run_next;
      skip_left      <= skip_left_next;
    end
  end

  // result count: load on a byte with results, else drain one per taken result
  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= 3'd0;
    end else if (in_fire && n_next != 3'd0) begin
      res_cnt <= n_next;
    end else if (out_fire) begin
      res_cnt <= res_cnt - 3'd1;
    end
  end

  // result classes, payload only
  always_ff @(posedge clk) begin
    if (in_fire && n_next != 3'd0) begin
      for (int k = 0; k < hmcc_pkg::MaxResults; k++) begin
        res_cls[k] <= cls_next[k];
      end
    end else if (out_fire) begin
      for (int k = 0; k < hmcc_pkg::MaxResults - 1; k++) begin
        res_cls[k] <= res_cls[k + 1];
      end
      res_cls[hmcc_pkg::MaxResults - 1] <= hmcc_pkg::CLS_NORMAL;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/hmcc_checker.sv
// port-level checks for the markup character classifier, bound to html_markup_char_classifier_core
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module hmcc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] char_class,
  input wire logic       run_last
);

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(char_class) && $stable(run_last), "stalled result changed")

  // no new request while more than one result of a byte is still waiting
  `ASSERT_SAME(a_no_accept_mid_run, clk, rst, out_valid && !run_last, !in_ready,
    "input ready during a result run")

  // an empty buffer always takes a request
  `ASSERT_SAME(a_ready_when_empty, clk, rst, !out_valid, in_ready,
    "input not ready with empty buffer")

  // a taken result that is not the last one is followed by another
  `ASSERT_NEXT(a_run_continues, clk, rst, out_valid && out_ready && !run_last, out_valid,
    "result run cut short")

endmodule

bind html_markup_char_classifier_core hmcc_checker u_hmcc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .char_class (char_class),
  .run_last   (run_last)
);

`default_nettype wire

>>> tb/html_markup_char_classifier_core_tb.sv
// self-checking testbench for html_markup_char_classifier_core
// sends directed rows and random utf-8 lines over valid/ready and checks every class
// depends on hmcc_pkg and html_markup_char_classifier_core
`timescale 1ns / 1ps

module html_markup_char_classifier_core_tb;
  import hmcc_pkg::*;

  localparam int CLK_PERIOD  = 4;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RAND_ITEMS  = 400;
  localparam int MAX_IDLE    = 13;
  localparam int DIR_N       = 27;

  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_EQ    = 8'h3D;

  // one expected class with its end-of-request flag
  typedef struct packed {
    class_t cls;
    logic   last;
  } char_res_t;

  // directed row: typed rows carry their expected classes
  typedef struct {
    logic [7:0] b;
    logic       le;
    logic       typed;
    int         n;
    class_t     c [4];
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] text_byte = 8'h00;
  logic       line_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] char_class;
  logic       run_last;

  char_res_t  exp_chars [$];
  logic [7:0] line_q [$];
  int         err_cnt = 0;
  int         cycle_cnt = 0;
  bit         burst = 1'b0;

  html_markup_char_classifier_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .text_byte (text_byte),
    .line_end  (line_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_class(char_class),
    .run_last  (run_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("html_markup_char_classifier_core_tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  mode_t      scan_st;
  logic [2:0] held_n;     // opener bytes held back, 0 to 3
  logic [1:0] dash_n;
  logic [1:0] skip_n;
  class_t     pred_cls [4];
  int         pred_n;

  function automatic void scan_clear();
    scan_st = MODE_NORMAL;
    held_n  = 3'd0;
    dash_n  = 2'd0;
    skip_n  = 2'd0;
  endfunction

  function automatic void put_class(class_t c);
    if (pred_n < MaxResults) begin
      pred_cls[pred_n] = c;
      pred_n++;
    end
  endfunction

  function automatic logic tail_byte(logic [7:0] b);
    return b[7] && !b[6];
  endfunction

  function automatic logic [1:0] lead_tail_len(logic [7:0] b);
    casez (b)
      8'b110?????: return 2'd1;
      8'b1110????: return 2'd2;
      8'b11110???: return 2'd3;
      default:     return 2'd0;
    endcase
  endfunction

  function automatic logic [7:0] opener_at(logic [2:0] idx);
    return (idx == 3'd1) ? CHAR_BANG : CHAR_DASH;
  endfunction

  function automatic void plain_byte(logic [7:0] b, class_t c);
    if (!tail_byte(b)) put_class(c);
    skip_n = lead_tail_len(b);
  endfunction

  function automatic void scan_markup(logic [7:0] b);
    case (scan_st)
      MODE_TAG: begin
        if (b == CHAR_GT) begin
          put_class(CLS_TAG);
          scan_st = MODE_NORMAL;
        end else if (b == CHAR_DQ) begin
          put_class(CLS_STRING);
          scan_st = MODE_DQ;
        end else if (b == CHAR_SQ) begin
          put_class(CLS_STRING);
          scan_st = MODE_SQ;
        end else begin
          plain_byte(b, CLS_TAG);
        end
      end
      MODE_DQ: begin
        if (b == CHAR_DQ) begin
          put_class(CLS_STRING);
          scan_st = MODE_TAG;
        end else begin
          plain_byte(b, CLS_STRING);
        end
      end
      MODE_SQ: begin
        if (b == CHAR_SQ) begin
          put_class(CLS_STRING);
          scan_st = MODE_TAG;
        end else begin
          plain_byte(b, CLS_STRING);
        end
      end
      default: begin
        // comment: closer needs two dashes right before the '>'
        if (b == CHAR_DASH) begin
          put_class(CLS_COMMENT);
          if (dash_n < 2'd2) dash_n = dash_n + 2'd1;
        end else if (b == CHAR_GT && dash_n >= 2'd2) begin
          put_class(CLS_COMMENT);
          scan_st = MODE_NORMAL;
          dash_n  = 2'd0;
        end else begin
          dash_n = 2'd0;
          plain_byte(b, CLS_COMMENT);
        end
      end
    endcase
  endfunction

  // held opener bytes turn out to be a plain tag
  function automatic void flush_held();
    for (int k = 0; k < int'(held_n); k++) put_class(CLS_TAG);
    if (held_n != 3'd0) scan_st = MODE_TAG;
    held_n = 3'd0;
  endfunction

  function automatic void classify_byte(logic [7:0] b, logic le);
    pred_n = 0;
    if (scan_st > MODE_COMMENT) scan_st = MODE_NORMAL;
    if (skip_n != 2'd0) begin
      skip_n = skip_n - 2'd1;
      if (!tail_byte(b)) put_class(CLS_NORMAL);
    end else if (scan_st == MODE_NORMAL) begin
      if (held_n != 3'd0) begin
        if (b == opener_at(held_n)) begin
          held_n = held_n + 3'd1;
          if (held_n == 3'd4) begin
            for (int k = 0; k < 4; k++) put_class(CLS_COMMENT);
            held_n  = 3'd0;
            scan_st = MODE_COMMENT;
            dash_n  = 2'd0;
          end
        end else begin
          flush_held();
          scan_markup(b);
        end
      end else if (b == CHAR_LT) begin
        held_n = 3'd1;
      end else if (!tail_byte(b)) begin
        put_class(CLS_NORMAL);
      end
    end else begin
      scan_markup(b);
    end
    if (le) begin
      flush_held();
      scan_clear();
    end
  endfunction

  function automatic void push_predicted();
    for (int k = 0; k < pred_n; k++) exp_chars.push_back('{pred_cls[k], k == pred_n - 1});
  endfunction

  // ---------------------------------------------------------------- request side
  task automatic send_byte(input logic [7:0] b, input logic le);
    int gap;
    gap = burst ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    text_byte <= b;
    line_end  <= le;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold the sender until every expected class has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_chars.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- line builder
  task automatic push_letters(input int cnt);
    for (int k = 0; k < cnt; k++) line_q.push_back(8'(8'h61 + $urandom_range(0, 25)));
  endtask

  // lead byte plus continuations, sometimes cut short
  task automatic push_utf8();
    int extra;
    extra = $urandom_range(1, 3);
    case (extra)
      1:       line_q.push_back(8'(8'hC0 | $urandom_range(0, 31)));
      2:       line_q.push_back(8'(8'hE0 | $urandom_range(0, 15)));
      default: line_q.push_back(8'(8'hF0 | $urandom_range(0, 7)));
    endcase
    for (int k = 0; k < extra; k++)
      if ($urandom_range(0, 7) != 0) line_q.push_back(8'(8'h80 | $urandom_range(0, 63)));
  endtask

  task automatic push_filler(input int cnt);
    for (int k = 0; k < cnt; k++) begin
      case ($urandom_range(0, 7))
        0:       push_letters(1);
        1:       line_q.push_back(CHAR_DASH);
        2:       line_q.push_back(CHAR_GT);
        3:       line_q.push_back(CHAR_DQ);
        4:       line_q.push_back(CHAR_SQ);
        5:       push_utf8();
        6:       line_q.push_back(8'($urandom_range(0, 255)));
        default: line_q.push_back(BYTE_SPACE);
      endcase
    end
  endtask

  // tags and comments, some broken, mixed with text, utf-8 bytes and noise
  task automatic build_line();
    int nseg;
    logic [7:0] q;
    line_q.delete();
    nseg = $urandom_range(1, 5);
    for (int s = 0; s < nseg; s++) begin
      case ($urandom_range(0, 9))
        0, 1: push_letters($urandom_range(1, 6));
        2: begin
          line_q.push_back(CHAR_LT);
          line_q.push_back(CHAR_BANG);
          line_q.push_back(CHAR_DASH);
          line_q.push_back(CHAR_DASH);
          push_filler($urandom_range(0, 6));
          if ($urandom_range(0, 3) != 0) begin
            line_q.push_back(CHAR_DASH);
            line_q.push_back(CHAR_DASH);
            line_q.push_back(CHAR_GT);
          end
        end
        3, 4: begin
          line_q.push_back(CHAR_LT);
          push_letters($urandom_range(1, 4));
          if ($urandom_range(0, 2) != 0) begin
            q = $urandom_range(0, 1) ? CHAR_DQ : CHAR_SQ;
            line_q.push_back(BYTE_SPACE);
            push_letters($urandom_range(1, 3));
            line_q.push_back(BYTE_EQ);
            line_q.push_back(q);
            push_filler($urandom_range(0, 4));
            if ($urandom_range(0, 5) != 0) line_q.push_back(q);
          end
          if ($urandom_range(0, 5) != 0) line_q.push_back(CHAR_GT);
        end
        5: push_utf8();
        6: line_q.push_back(8'($urandom_range(0, 255)));
        7: begin
          case ($urandom_range(0, 5))
            0:       line_q.push_back(CHAR_LT);
            1:       line_q.push_back(CHAR_GT);
            2:       line_q.push_back(CHAR_BANG);
            3:       line_q.push_back(CHAR_DASH);
            4:       line_q.push_back(CHAR_DQ);
            default: line_q.push_back(CHAR_SQ);
          endcase
        end
        8: begin
          // opener that breaks off part way
          line_q.push_back(CHAR_LT);
          if ($urandom_range(0, 3) != 0) line_q.push_back(CHAR_BANG);
          if ($urandom_range(0, 1) != 0) line_q.push_back(CHAR_DASH);
          line_q.push_back(8'($urandom_range(0, 255)));
        end
        default: push_filler($urandom_range(1, 4));
      endcase
    end
  endtask

  // ---------------------------------------------------------------- directed rows
  dir_row_t dir_rows [DIR_N] = '{
    '{8'h00,     1'b0, 1'b1, 1, '{CLS_NORMAL, CLS_NORMAL, CLS_NORMAL, CLS_NORMAL}},
    '{8'hFF,     1'b0, 1'b1, 1, '{CLS_NORMAL, CLS_NORMAL, CLS_NORMAL, CLS_NORMAL}},
    '{8'hBF,     1'b0, 1'b1, 0, '{CLS_NORMAL, CLS_NORMAL, CLS_NORMAL, CLS_NORMAL}},
    // comment opener held back, then released all at once
    '{CHAR_LT,   1'b0, 1'b1, 0, '{CLS_NORMAL, CLS_NORMAL, CLS_NORMAL, CLS_NORMAL}},
    '{CHAR_BANG, 1'b0, 1'b1, 0, '{CLS_NORMAL, CLS_NORMAL, CLS_NORMAL, CLS_NORMAL}},
    '{CHAR_DASH, 1'b0, 1'b1, 0, '{CLS_NORMAL, CLS_NORMAL, CLS_NORMAL, CLS_NORMAL}},
    '{CHAR_DASH, 1'b0, 1'b1, 4, '{CLS_COMMENT, CLS_COMMENT, CLS_COMMENT, CLS_COMMENT}},
    // two-byte lead in a comment, skipped byte is not a continuation
    '{8'hC5,     1'b0, 1'b0, 0, '{CLS_NORMAL, CLS_NORMAL, CLS_NORMAL, CLS_NORMAL}},
    '{8'h41,     1'b0, 1'b0, 0, '{CLS_NORMAL, CLS_NORMAL, CLS_NORMAL, CLS_NORMAL}},
    '{CHAR_DASH, 1'b0, 1'b0, 0, '{CLS_NORMAL, CLS_NORMAL, CLS_NORMAL, CLS_NORMAL}},
    '{CHAR_DASH, 1'b0, 1'b0, 0, '{CLS_NORMAL, CLS_NORMAL, CLS_NORMAL, CLS_NORMAL}},
    '{CHAR_GT,   1'b0, 1'b0, 0, '{CLS_NORMAL, CLS_NORMAL, CLS_NORMAL, CLS_NORMAL}},
    // plain tag: held '<' falls back to tag class
    '{CHAR_LT,   1'b0, 1'b0, 0, '{CLS_NORMAL, CLS_NORMAL, CLS_NORMAL, CLS_NORMAL}},
    '{8'h70,     1'b0, 1'b0, 0, '{CLS_NORMAL, CLS_NORMAL, CLS_NORMAL, CLS_NORMAL}},
    '{CHAR_DQ,   1'b0, 1'b0, 0, '{CLS_NORMAL, CLS_NORMAL, CLS_NORMAL, CLS_NORMAL}},
    '{8'hC3,     1'b0, 1'b0, 0, '{CLS_NORMAL, CLS_NORMAL, CLS_NORMAL, CLS_NORMAL}},
    '{CHAR_DQ,   1'b0, 1'b0, 0, '{CLS_NORMAL, CLS_NORMAL, CLS_NORMAL, CLS_NORMAL}},
    '{CHAR_DQ,   1'b0, 1'b0, 0, '{CLS_NORMAL, CLS_NORMAL, CLS_NORMAL, CLS_NORMAL}},
    '{CHAR_SQ,   1'b0, 1'b0, 0, '{CLS_NORMAL, CLS_NORMAL, CLS_NORMAL, CLS_NORMAL}},
    '{CHAR_SQ,   1'b1, 1'b0, 0, '{CLS_NORMAL, CLS_NORMAL, CLS_NORMAL, CLS_NORMAL}},
    // opener broken after three bytes: four results from one byte
    '{CHAR_LT,   1'b0, 1'b0, 0, '{CLS_NORMAL, CLS_NORMAL, CLS_NORMAL, CLS_NORMAL}},
    '{CHAR_BANG, 1'b0, 1'b0, 0, '{CLS_NORMAL, CLS_NORMAL, CLS_NORMAL, CLS_NORMAL}},
    '{CHAR_DASH, 1'b0, 1'b0, 0, '{CLS_NORMAL, CLS_NORMAL, CLS_NORMAL, CLS_NORMAL}},
    '{8'h78,     1'b0, 1'b0, 0, '{CLS_NORMAL, CLS_NORMAL, CLS_NORMAL, CLS_NORMAL}},
    // lead byte on a line end inside a tag: classed tag, no skip starts
    '{8'hF0,     1'b1, 1'b0, 0, '{CLS_NORMAL, CLS_NORMAL, CLS_NORMAL, CLS_NORMAL}},
    // line end flushes held opener bytes
    '{CHAR_LT,   1'b0, 1'b0, 0, '{CLS_NORMAL, CLS_NORMAL, CLS_NORMAL, CLS_NORMAL}},
    '{CHAR_BANG, 1'b1, 1'b1, 2, '{CLS_TAG, CLS_TAG, CLS_NORMAL, CLS_NORMAL}}
  };

  // ---------------------------------------------------------------- result side
  initial begin
    int stall;
    char_res_t e;
    while (rst) @(posedge clk);
    forever begin
      stall = burst ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (exp_chars.size() == 0) begin
        $error("unexpected result: char_class %0d run_last %0d", char_class, run_last);
        err_cnt++;
      end else begin
        e = exp_chars.pop_front();
        if (char_class !== e.cls) begin
          $error("char_class: expected %0d, got %0d", e.cls, char_class);
          err_cnt++;
        end
        if (run_last !== e.last) begin
          $error("run_last: expected %0d, got %0d", e.last, run_last);
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- main sequence
  initial begin
    int items;
    bit drained_mid;
    items = 0;
    drained_mid = 1'b0;
    scan_clear();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      send_byte(dir_rows[i].b, dir_rows[i].le);
      classify_byte(dir_rows[i].b, dir_rows[i].le);
      if (dir_rows[i].typed) begin
        for (int k = 0; k < dir_rows[i].n; k++)
          exp_chars.push_back('{dir_rows[i].c[k], k == dir_rows[i].n - 1});
      end else begin
        push_predicted();
      end
    end
    drain_results();

    while (items < RAND_ITEMS) begin
      build_line();
      burst = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < line_q.size(); k++) begin
        send_byte(line_q[k], k == line_q.size() - 1);
        classify_byte(line_q[k], k == line_q.size() - 1);
        push_predicted();
        items++;
      end
      if (!drained_mid && items >= RAND_ITEMS / 2) begin
        drain_results();
        drained_mid = 1'b1;
      end
    end

    drain_results();
    // wait on to catch any stray result
    repeat (16) @(posedge clk);
    if (err_cnt == 0) begin
      $display("html_markup_char_classifier_core_tb passed");
    end else begin
      $display("html_markup_char_classifier_core_tb failed");
    end
    $finish;
  end

endmodule

>>> html_markup_char_classifier_core.f
+incdir+rtl/core
rtl/core/hmcc_pkg.sv
rtl/core/html_markup_char_classifier_core.sv
rtl/core/hmcc_checker.sv
tb/html_markup_char_classifier_core_tb.sv
